[rtl/core/legendre_lens_distortion_map_unit_macros.svh]
// Assertion helpers; clock i_clk, synchronous active-low reset i_rst_n.
`ifndef LEGENDRE_LENS_DISTORTION_MAP_UNIT_MACROS_SVH
`define LEGENDRE_LENS_DISTORTION_MAP_UNIT_MACROS_SVH

// Same-cycle implication.
`define LLDM_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define LLDM_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/lldm_pkg.sv]
`default_nettype none

package lldm_pkg;

    localparam int NUM_TERMS = 20;
    localparam int NUM_COEF  = 2 * NUM_TERMS;
    localparam int MW        = 35;       // multiplier operand width
    localparam int PW        = 2 * MW;   // product width

    localparam logic [1:0] ACT_LOAD = 2'd0;
    localparam logic [1:0] ACT_FWD  = 2'd1;
    localparam logic [1:0] ACT_INV  = 2'd2;
    localparam logic [1:0] ACT_NONE = 2'd3;

    localparam logic [1:0] STAT_OK     = 2'd0;
    localparam logic [1:0] STAT_RANGE  = 2'd1;
    localparam logic [1:0] STAT_NOCONV = 2'd2;

    localparam logic [2:0] CFG_HW_X   = 3'd0;
    localparam logic [2:0] CFG_HW_Y   = 3'd1;
    localparam logic [2:0] CFG_RCP_X  = 3'd2;
    localparam logic [2:0] CFG_RCP_Y  = 3'd3;
    localparam logic [2:0] CFG_TOL    = 3'd4;
    localparam logic [2:0] CFG_MAXIT  = 3'd5;

    localparam logic [6:0] ITER_CAP = 7'd64;

    localparam logic [2:0] DEG_X [NUM_TERMS] =
        '{0, 1, 0, 1, 2, 0, 1, 2, 3, 0, 1, 2, 3, 4, 0, 1, 2, 3, 4, 5};
    localparam logic [2:0] DEG_Y [NUM_TERMS] =
        '{1, 0, 2, 1, 0, 3, 2, 1, 0, 4, 3, 2, 1, 0, 5, 4, 3, 2, 1, 0};

    typedef struct packed {
        logic [1:0]         action;
        logic signed [31:0] coord_x;
        logic signed [31:0] coord_y;
        logic [5:0]         coef_index;
        logic signed [31:0] coef_value;
    } t_req;

    typedef struct packed {
        logic signed [31:0] result_x;
        logic signed [31:0] result_y;
        logic [1:0]         status;
    } t_rsp;

    // round half up then arithmetic shift
    function automatic logic signed [PW-1:0] rnd_p(input logic signed [PW-1:0] v,
                                                   input int unsigned s);
        return (v + (PW'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [51:0] v);
        logic signed [31:0] res;
        if (v > 52'sd2147483647) begin
            res = 32'sh7fffffff;
        end else if (v < -52'sd2147483648) begin
            res = 32'sh80000000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

    function automatic logic out_rng(input logic signed [49:0] v);
        return (v > 50'sd1073741824) || (v < -50'sd1073741824);
    endfunction

    // Legendre term of given degree from stored powers (Q2.30)
    function automatic logic signed [33:0] legendre(input logic [2:0] deg,
            input logic signed [31:0] p1, input logic signed [31:0] p2,
            input logic signed [31:0] p3, input logic signed [31:0] p4,
            input logic signed [31:0] p5);
        logic signed [39:0] v1, v2, v3, v4, v5, acc;
        logic signed [33:0] res;
        v1  = 40'(p1);
        v2  = 40'(p2);
        v3  = 40'(p3);
        v4  = 40'(p4);
        v5  = 40'(p5);
        acc = '0;
        case (deg)
            3'd0: res = 34'sd1073741824;
            3'd1: res = 34'(v1);
            3'd2: begin
                acc = 40'sd3 * v2 - 40'sd1073741824;
                res = 34'((acc + 40'sd1) >>> 1);
            end
            3'd3: begin
                acc = 40'sd5 * v3 - 40'sd3 * v1;
                res = 34'((acc + 40'sd1) >>> 1);
            end
            3'd4: begin
                acc = 40'sd35 * v4 - 40'sd30 * v2 + 40'sd3221225472;
                res = 34'((acc + 40'sd4) >>> 3);
            end
            3'd5: begin
                acc = 40'sd63 * v5 - 40'sd70 * v3 + 40'sd15 * v1;
                res = 34'((acc + 40'sd4) >>> 3);
            end
            default: res = '0;
        endcase
        return res;
    endfunction

endpackage

`default_nettype wire

[rtl/core/lldm_if.sv]
`default_nettype none

interface lldm_req_if;
    logic          valid;
    logic          ready;
    lldm_pkg::t_req data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface lldm_rsp_if;
    logic          valid;
    logic          ready;
    lldm_pkg::t_rsp data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/core/lldm_ram.sv]
`default_nettype none

module lldm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 40
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[rtl/core/lldm_mul.sv]
`default_nettype none

module lldm_mul #(
    parameter int W = 35
) (
    input  wire logic                  i_clk,
    input  wire logic signed [W-1:0]   i_a,
    input  wire logic signed [W-1:0]   i_b,
    output logic signed [2*W-1:0]      o_p
);

    logic signed [2*W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule

`default_nettype wire

[rtl/core/legendre_lens_distortion_map_unit.sv]
// Forward mapping runs one evaluation from request to result; inverse mapping
// runs one evaluation per iteration for N iterations, until it converges or hits the limit
// (N at most 64). Out-of-range requests finish early.
// Each evaluation does 1 range check, 9 power steps and 20 terms on the
// single shared multiplier, paced by the coefficient RAM read
// and three multiplies per term, plus 1 update. One request in flight; loads
// leave the unit idle. Reset restores the register defaults; the coefficient RAM is
// undefined until loaded (no clearing pass).
`default_nettype none

module legendre_lens_distortion_map_unit #(
    parameter int COEF_WIDTH = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    lldm_req_if.sink         i_req,
    lldm_rsp_if.source       o_rsp,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [31:0] i_cfg_data
);

    `include "legendre_lens_distortion_map_unit_macros.svh"

    localparam int MW = lldm_pkg::MW;
    localparam int PW = lldm_pkg::PW;
    localparam int LW = (COEF_WIDTH < 32) ? COEF_WIDTH : 32;
    localparam int AW = $clog2(lldm_pkg::NUM_COEF);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_NORM  = 3'd1;
    localparam logic [2:0] ST_CHECK = 3'd2;
    localparam logic [2:0] ST_POW   = 3'd3;
    localparam logic [2:0] ST_TERM  = 3'd4;
    localparam logic [2:0] ST_UPD   = 3'd5;
    localparam logic [2:0] ST_MM    = 3'd6;
    localparam logic [2:0] ST_OUT   = 3'd7;

    // configuration
    logic [30:0] r_hw_x, r_hw_y;
    logic [31:0] r_rcp_x, r_rcp_y;
    logic [29:0] r_tol;
    logic [6:0]  r_maxit;

    // control
    logic [2:0] r_state;
    logic [3:0] r_sub;
    logic [4:0] r_k;
    logic [6:0] r_iter;
    logic [1:0] r_act;
    logic [1:0] r_stat;
    logic       r_ovalid;
    lldm_pkg::t_rsp r_rsp;

    // datapath
    logic signed [31:0] r_cx, r_cy;
    logic signed [49:0] r_nx, r_ny, r_tx, r_ty;
    logic signed [31:0] r_px [5];
    logic signed [31:0] r_py [5];
    logic signed [33:0] r_t;
    logic signed [MW-1:0] r_coefx, r_coefy;
    logic signed [41:0] r_sx, r_sy;
    logic signed [31:0] r_rx, r_ry;

    logic signed [MW-1:0] w_ma, w_mb;
    logic signed [PW-1:0] w_prod;
    logic                 w_acc, w_we;
    logic [AW-1:0]        w_raddr;
    logic [COEF_WIDTH-1:0] w_wdata, w_rdata;
    logic signed [LW-1:0] w_coef_lo;
    logic [6:0]           w_lim;
    logic [3:0]           w_j;
    logic [2:0]           w_dst;
    logic signed [51:0]   w_sumx, w_sumy, w_ex, w_ey;
    logic [51:0]          w_ax, w_ay;
    logic signed [49:0]   n_tx, n_ty;
    logic                 w_conv;

    assign i_req.ready = (r_state == ST_IDLE);
    assign w_acc = i_req.valid && i_req.ready;

    assign w_coef_lo = i_req.data.coef_value[LW-1:0];
    assign w_wdata   = COEF_WIDTH'(w_coef_lo);
    assign w_we      = w_acc && (i_req.data.action == lldm_pkg::ACT_LOAD)
                       && (i_req.data.coef_index < 6'(lldm_pkg::NUM_COEF));
    assign w_raddr   = (r_sub == 4'd0) ? AW'(r_k) : AW'(r_k) + AW'(lldm_pkg::NUM_TERMS);

    lldm_ram #(
        .WIDTH (COEF_WIDTH),
        .DEPTH (lldm_pkg::NUM_COEF)
    ) u_coef_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (i_req.data.coef_index[AW-1:0]),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    lldm_mul #(
        .W (MW)
    ) u_mul (
        .i_clk (i_clk),
        .i_a   (w_ma),
        .i_b   (w_mb),
        .o_p   (w_prod)
    );

    // operand select for the shared multiplier
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        case (r_state)
            ST_NORM: begin
                if (r_sub == 4'd0) begin
                    w_ma = MW'(r_cx);
                    w_mb = $signed({3'b000, r_rcp_x});
                end else begin
                    w_ma = MW'(r_cy);
                    w_mb = $signed({3'b000, r_rcp_y});
                end
            end
            ST_POW: begin
                // interleave axes so each power is ready before its reuse
                if (r_sub[0]) begin
                    w_ma = MW'(r_py[{1'b0, r_sub[2:1]}]);
                    w_mb = MW'(r_py[0]);
                end else begin
                    w_ma = MW'(r_px[{1'b0, r_sub[2:1]}]);
                    w_mb = MW'(r_px[0]);
                end
            end
            ST_TERM: begin
                if (r_sub == 4'd0) begin
                    w_ma = MW'(lldm_pkg::legendre(lldm_pkg::DEG_X[r_k],
                        r_px[0], r_px[1], r_px[2], r_px[3], r_px[4]));
                    w_mb = MW'(lldm_pkg::legendre(lldm_pkg::DEG_Y[r_k],
                        r_py[0], r_py[1], r_py[2], r_py[3], r_py[4]));
                end else if (r_sub == 4'd2) begin
                    w_ma = r_coefx;
                    w_mb = MW'(r_t);
                end else begin
                    w_ma = r_coefy;
                    w_mb = MW'(r_t);
                end
            end
            ST_MM: begin
                if (r_sub == 4'd0) begin
                    w_ma = MW'($signed(r_tx[31:0]));
                    w_mb = $signed({4'b0000, r_hw_x});
                end else begin
                    w_ma = MW'($signed(r_ty[31:0]));
                    w_mb = $signed({4'b0000, r_hw_y});
                end
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    assign w_j   = r_sub - 4'd1;
    assign w_dst = 3'(w_j[2:1]) + 3'd1;

    assign w_lim = (r_maxit == 7'd0) ? 7'd1 :
                   ((r_maxit > lldm_pkg::ITER_CAP) ? lldm_pkg::ITER_CAP : r_maxit);

    // correction update; forward adds, inverse subtracts from the start point
    always_comb begin
        if (r_act == lldm_pkg::ACT_FWD) begin
            w_sumx = 52'(r_nx) + 52'(r_sx);
            w_sumy = 52'(r_ny) + 52'(r_sy);
        end else begin
            w_sumx = 52'(r_nx) - 52'(r_sx);
            w_sumy = 52'(r_ny) - 52'(r_sy);
        end
        n_tx   = 50'(lldm_pkg::sat32(w_sumx));
        n_ty   = 50'(lldm_pkg::sat32(w_sumy));
        w_ex   = 52'(n_tx) - 52'(r_tx);
        w_ey   = 52'(n_ty) - 52'(r_ty);
        w_ax   = w_ex[51] ? 52'(-w_ex) : 52'(w_ex);
        w_ay   = w_ey[51] ? 52'(-w_ey) : 52'(w_ey);
        w_conv = (r_iter != 7'd0) && (w_ax <= 52'(r_tol)) && (w_ay <= 52'(r_tol));
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hw_x  <= 31'd34242298;
            r_hw_y  <= 31'd872415;
            r_rcp_x <= 32'd513755;
            r_rcp_y <= 32'd20165019;
            r_tol   <= 30'd1074;
            r_maxit <= 7'd50;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                lldm_pkg::CFG_HW_X:  r_hw_x  <= i_cfg_data[30:0];
                lldm_pkg::CFG_HW_Y:  r_hw_y  <= i_cfg_data[30:0];
                lldm_pkg::CFG_RCP_X: r_rcp_x <= i_cfg_data;
                lldm_pkg::CFG_RCP_Y: r_rcp_y <= i_cfg_data;
                lldm_pkg::CFG_TOL:   r_tol   <= i_cfg_data[29:0];
                lldm_pkg::CFG_MAXIT: r_maxit <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_sub    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            // ST_OUT owns the valid flag while it loads a new result
            if (r_ovalid && o_rsp.ready && (r_state != ST_OUT)) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_acc) begin
                        r_act <= i_req.data.action;
                        r_cx  <= i_req.data.coord_x;
                        r_cy  <= i_req.data.coord_y;
                        r_sub <= '0;
                        if (i_req.data.action == lldm_pkg::ACT_FWD ||
                            i_req.data.action == lldm_pkg::ACT_INV) begin
                            r_state <= ST_NORM;
                        end
                    end
                end
                ST_NORM: begin
                    r_sub <= r_sub + 4'd1;
                    if (r_sub == 4'd1) begin
                        r_nx <= 50'(lldm_pkg::rnd_p(w_prod, 14));
                    end else if (r_sub == 4'd2) begin
                        r_ny    <= 50'(lldm_pkg::rnd_p(w_prod, 14));
                        r_tx    <= r_nx;
                        r_ty    <= 50'(lldm_pkg::rnd_p(w_prod, 14));
                        r_iter  <= '0;
                        r_state <= ST_CHECK;
                    end
                end
                ST_CHECK: begin
                    if (lldm_pkg::out_rng(r_tx) || lldm_pkg::out_rng(r_ty)) begin
                        r_stat  <= lldm_pkg::STAT_RANGE;
                        r_state <= ST_OUT;
                    end else begin
                        r_px[0] <= r_tx[31:0];
                        r_py[0] <= r_ty[31:0];
                        r_sx    <= '0;
                        r_sy    <= '0;
                        r_k     <= '0;
                        r_sub   <= '0;
                        r_state <= ST_POW;
                    end
                end
                ST_POW: begin
                    if (r_sub != 4'd0) begin
                        if (w_j[0]) begin
                            r_py[w_dst] <= 32'(lldm_pkg::rnd_p(w_prod, 30));
                        end else begin
                            r_px[w_dst] <= 32'(lldm_pkg::rnd_p(w_prod, 30));
                        end
                    end
                    if (r_sub == 4'd8) begin
                        r_sub   <= '0;
                        r_state <= ST_TERM;
                    end else begin
                        r_sub <= r_sub + 4'd1;
                    end
                end
                ST_TERM: begin
                    r_sub <= r_sub + 4'd1;
                    case (r_sub)
                        4'd1: begin
                            r_t     <= 34'(lldm_pkg::rnd_p(w_prod, 30));
                            r_coefx <= MW'($signed(w_rdata));
                        end
                        4'd2: r_coefy <= MW'($signed(w_rdata));
                        4'd3: r_sx <= r_sx + 42'(lldm_pkg::rnd_p(w_prod, 28));
                        4'd4: begin
                            r_sy  <= r_sy + 42'(lldm_pkg::rnd_p(w_prod, 28));
                            r_sub <= '0;
                            if (r_k == 5'(lldm_pkg::NUM_TERMS - 1)) begin
                                r_state <= ST_UPD;
                            end else begin
                                r_k <= r_k + 5'd1;
                            end
                        end
                        default: ;
                    endcase
                end
                ST_UPD: begin
                    r_tx  <= n_tx;
                    r_ty  <= n_ty;
                    r_sub <= '0;
                    if (r_act == lldm_pkg::ACT_FWD || w_conv) begin
                        r_state <= ST_MM;
                    end else if (7'(r_iter + 7'd1) == w_lim) begin
                        r_stat  <= lldm_pkg::STAT_NOCONV;
                        r_state <= ST_OUT;
                    end else begin
                        r_iter  <= r_iter + 7'd1;
                        r_state <= ST_CHECK;
                    end
                end
                ST_MM: begin
                    r_sub <= r_sub + 4'd1;
                    if (r_sub == 4'd1) begin
                        r_rx <= lldm_pkg::sat32(52'(lldm_pkg::rnd_p(w_prod, 30)));
                    end else if (r_sub == 4'd2) begin
                        r_ry    <= lldm_pkg::sat32(52'(lldm_pkg::rnd_p(w_prod, 30)));
                        r_stat  <= lldm_pkg::STAT_OK;
                        r_state <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (!r_ovalid || o_rsp.ready) begin
                        r_rsp.result_x <= (r_stat == lldm_pkg::STAT_OK) ? r_rx : '0;
                        r_rsp.result_y <= (r_stat == lldm_pkg::STAT_OK) ? r_ry : '0;
                        r_rsp.status   <= r_stat;
                        r_ovalid       <= 1'b1;
                        r_state        <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_rsp.valid = r_ovalid;
    assign o_rsp.data  = r_rsp;

    `LLDM_ASSERT_IMP(a_term_bounds, r_state == ST_TERM, (r_k < 5'(lldm_pkg::NUM_TERMS)) && (r_sub < 4'd5), "term sequencer out of bounds")
    `LLDM_ASSERT_IMP(a_iter_limit, (r_state == ST_UPD) && (r_act == lldm_pkg::ACT_INV), r_iter < w_lim, "inverse iteration past limit")
    `LLDM_ASSERT_NXT(a_load_idle, w_acc && (i_req.data.action == lldm_pkg::ACT_LOAD), r_state == ST_IDLE, "load left idle")
    `LLDM_ASSERT_IMP(a_err_zero, o_rsp.valid && (o_rsp.data.status != lldm_pkg::STAT_OK), (o_rsp.data.result_x == 32'sd0) && (o_rsp.data.result_y == 32'sd0), "error result not zeroed")

endmodule

`default_nettype wire
